// File: sv/rolling_window_price_stats_macros.svh
// Assertion helpers for the design file that checks its own logic.
`ifndef ROLLING_WINDOW_PRICE_STATS_MACROS_SVH
`define ROLLING_WINDOW_PRICE_STATS_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define RWPS_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define RWPS_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define RWPS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/rwps_pkg.sv
package rwps_pkg;

  localparam int HISTORY_DEPTH_DEF = 1024;

  localparam int PRICE_W = 32;
  localparam int TIME_W  = 64;
  localparam int WIN_W   = 50;
  localparam int VAR_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int COUNT_W = 11;
  localparam int PC_W    = 33;
  localparam int PIP_W   = 27;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 264;
  localparam int CFG_IDX_W  = 8;

  localparam logic [WIN_W-1:0] SHORT_RESET = 50'd3600000000000;
  localparam logic [WIN_W-1:0] LONG_RESET  = 50'd86400000000000;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_WINDOW = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_WINDOW  = 8'd1;

  // floor(n / 100) == (n * PIP_RECIP) >> PIP_SHIFT for every 32-bit n.
  localparam logic [31:0] PIP_RECIP = 32'd1374389535;
  localparam int          PIP_SHIFT = 37;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// File: sv/rolling_window_price_stats.sv
// Channel     Direction  Beat contents
// s_axis_*    in         one tick: tdata = tick_price, tick_time
// m_axis_*    out        one window result: tdata = statistics, tuser = window_kind,
//                        tlast = last_result (set on the long-window beat)
// cfg_*       in         register write: cfg_index selects the register, cfg_data the value
//
// Each tick runs two sweeps of the stored ticks (up to HISTORY_DEPTH) over the single read
// port, four divides, two square roots, the pip step, two result beats and a return to idle.
// Reset is synchronous and active high; it empties the history and restores the default
// window lengths. The input is ready only while idle; result beats wait on m_axis_tready.
`include "rolling_window_price_stats_macros.svh"

module rolling_window_price_stats #(
  parameter int HISTORY_DEPTH = rwps_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // tick_price [31:0], tick_time [95:32]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rwps_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // span_start [63:0], span_end [127:64], window_count [138:128], avg_price [170:139],
  // volatility [202:171], price_delta [235:203], pip_delta [262:236], zero [263]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [rwps_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // window_kind [0]
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rwps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rwps_pkg::WIN_W-1:0]          cfg_data
);

  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int CW     = $clog2(HISTORY_DEPTH + 1);
  localparam int PW     = rwps_pkg::PRICE_W;
  localparam int TW     = rwps_pkg::TIME_W;
  localparam int SUM_W  = PW + CW;
  localparam int ACC_W  = 2 * PW + CW;
  localparam int RAM_W  = PW + TW;

  // One-hot sequencer: first sweep, mean divides, second sweep, variance divides, roots, pip step and result beats.
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN1 = 8'b0000_0010,
    S_MDIV  = 8'b0000_0100,
    S_SCAN2 = 8'b0000_1000,
    S_VDIV  = 8'b0001_0000,
    S_SQRT  = 8'b0010_0000,
    S_PIP   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state;

  logic [rwps_pkg::WIN_W-1:0] short_len;
  logic [rwps_pkg::WIN_W-1:0] long_len;

  logic [AW-1:0] wp;
  logic [CW-1:0] fill;
  logic [AW-1:0] wp_next;
  logic [CW-1:0] fill_next;

  logic [TW-1:0] t_cur;
  logic [TW-1:0] start_w [2];

  logic [CW-1:0] k;
  logic [AW-1:0] rd_addr;
  logic          rd_vld;
  logic          issue;

  logic [CW-1:0]    cnt   [2];
  logic [SUM_W-1:0] sum   [2];
  logic [PW-1:0]    first [2];
  logic [PW-1:0]    last  [2];
  logic [PW-1:0]    mean  [2];
  logic [PW-1:0]    d     [2];
  logic [1:0]       dv;
  logic [2*PW-1:0]  sq    [2];
  logic [1:0]       sqv;
  logic [ACC_W-1:0] acc   [2];
  logic [rwps_pkg::VAR_W-1:0]  var_r [2];
  logic [rwps_pkg::ROOT_W-1:0] vol   [2];
  logic [2*PW-1:0]  prod  [2];

  logic win;
  logic launched;

  logic          in_beat;
  logic [PW-1:0] in_price;
  logic [TW-1:0] in_time;
  logic [TW-1:0] short_ext;
  logic [TW-1:0] long_ext;

  logic [RAM_W-1:0] rdata;
  logic [PW-1:0]    rd_p;
  logic [TW-1:0]    rd_t;
  logic [1:0]       inwin;

  logic                 div_start;
  logic [ACC_W-1:0]     div_num;
  logic [ACC_W-1:0]     div_quo;
  rwps_pkg::unit_stat_t div_stat;
  logic                 sqrt_start;
  logic [rwps_pkg::ROOT_W-1:0] sqrt_root;
  rwps_pkg::unit_stat_t sqrt_stat;

  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_price      = s_axis_tdata[PW-1:0];
  assign in_time       = s_axis_tdata[PW+TW-1:PW];
  assign short_ext     = TW'(short_len);
  assign long_ext      = TW'(long_len);

  assign wp_next   = (wp == AW'(HISTORY_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign fill_next = (fill == CW'(HISTORY_DEPTH)) ? fill : fill + 1'b1;

  // Both sweeps read the ring oldest first; one address goes out per cycle.
  assign issue = ((state == S_SCAN1) || (state == S_SCAN2)) && (k != fill);

  rwps_ram #(
    .WIDTH (RAM_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (in_beat),
    .waddr (wp),
    .wdata ({in_time, in_price}),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign rd_p = rdata[PW-1:0];
  assign rd_t = rdata[RAM_W-1:PW];

  always_comb begin
    for (int w = 0; w < 2; w++) begin
      inwin[w] = (rd_t >= start_w[w]) && (rd_t <= t_cur);
    end
  end

  // The divider serves both the mean (sum / count) and the variance (squares / count).
  assign div_num   = (state == S_MDIV) ? ACC_W'(sum[win]) : acc[win];
  assign div_start = ((state == S_MDIV) || (state == S_VDIV)) && !launched;

  rwps_div #(
    .NUM_W (ACC_W),
    .DEN_W (CW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (cnt[win]),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  assign sqrt_start = (state == S_SQRT) && !launched;

  rwps_isqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (var_r[win]),
    .stat  (sqrt_stat),
    .root  (sqrt_root)
  );

  // Configuration writes; an index beyond the register list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      short_len <= rwps_pkg::SHORT_RESET;
      long_len  <= rwps_pkg::LONG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rwps_pkg::REG_SHORT_WINDOW: short_len <= cfg_data;
        rwps_pkg::REG_LONG_WINDOW:  long_len  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Read pipeline of the sweeps, with the squaring stages of the second sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      dv     <= '0;
      sqv    <= '0;
    end else begin
      rd_vld <= issue;
      for (int w = 0; w < 2; w++) begin
        dv[w]  <= rd_vld && (state == S_SCAN2) && inwin[w];
        sqv[w] <= dv[w];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < 2; w++) begin
      d[w]  <= (rd_p >= mean[w]) ? rd_p - mean[w] : mean[w] - rd_p;
      sq[w] <= d[w] * d[w];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wp       <= '0;
      fill     <= '0;
      win      <= 1'b0;
      launched <= 1'b0;
      k        <= '0;
    end else begin
      if (issue) begin
        k       <= k + 1'b1;
        rd_addr <= (rd_addr == AW'(HISTORY_DEPTH - 1)) ? '0 : rd_addr + 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            wp      <= wp_next;
            fill    <= fill_next;
            t_cur   <= in_time;
            start_w[0] <= (in_time >= short_ext) ? in_time - short_ext : '0;
            start_w[1] <= (in_time >= long_ext) ? in_time - long_ext : '0;
            k       <= '0;
            // Until the ring has wrapped, the oldest entry sits at slot zero.
            rd_addr <= (fill_next == CW'(HISTORY_DEPTH)) ? wp_next : '0;
            for (int w = 0; w < 2; w++) begin
              cnt[w] <= '0;
              sum[w] <= '0;
            end
            state <= S_SCAN1;
          end
        end

        S_SCAN1: begin
          if (rd_vld) begin
            for (int w = 0; w < 2; w++) begin
              if (inwin[w]) begin
                if (cnt[w] == '0) begin
                  first[w] <= rd_p;
                end
                last[w] <= rd_p;
                sum[w]  <= sum[w] + SUM_W'(rd_p);
                cnt[w]  <= cnt[w] + 1'b1;
              end
            end
          end
          if ((k == fill) && !rd_vld) begin
            win   <= 1'b0;
            state <= S_MDIV;
          end
        end

        S_MDIV: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (div_stat.done) begin
            launched  <= 1'b0;
            mean[win] <= div_quo[PW-1:0];
            win       <= ~win;
            if (win) begin
              k       <= '0;
              rd_addr <= (fill == CW'(HISTORY_DEPTH)) ? wp : '0;
              acc[0]  <= '0;
              acc[1]  <= '0;
              state   <= S_SCAN2;
            end
          end
        end

        S_SCAN2: begin
          for (int w = 0; w < 2; w++) begin
            if (sqv[w]) begin
              acc[w] <= acc[w] + ACC_W'(sq[w]);
            end
          end
          if ((k == fill) && !rd_vld && (dv == '0) && (sqv == '0)) begin
            win   <= 1'b0;
            state <= S_VDIV;
          end
        end

        S_VDIV: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (div_stat.done) begin
            launched   <= 1'b0;
            var_r[win] <= div_quo[rwps_pkg::VAR_W-1:0];
            win        <= ~win;
            if (win) begin
              state <= S_SQRT;
            end
          end
        end

        S_SQRT: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (sqrt_stat.done) begin
            launched <= 1'b0;
            vol[win] <= sqrt_root;
            win      <= ~win;
            if (win) begin
              state <= S_PIP;
            end
          end
        end

        S_PIP: begin
          // Pip magnitude by reciprocal multiply; the sign is applied on output.
          for (int w = 0; w < 2; w++) begin
            prod[w] <= ((last[w] >= first[w]) ? last[w] - first[w] : first[w] - last[w])
                       * rwps_pkg::PIP_RECIP;
          end
          win   <= 1'b0;
          state <= S_OUT;
        end

        S_OUT: begin
          if (m_axis_tready) begin
            win <= ~win;
            if (win) begin
              state <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Result beat assembly for the window selected by win.
  logic                          nz;
  logic                          neg;
  logic [CW+rwps_pkg::COUNT_W-1:0] cnt_ext;
  logic [rwps_pkg::PC_W-1:0]     pc_o;
  logic [rwps_pkg::PIP_W-1:0]    pip_mag;
  logic [rwps_pkg::PIP_W-1:0]    pip_o;
  logic [PW-1:0]                 mean_o;
  logic [PW-1:0]                 vol_o;

  always_comb begin
    nz      = (cnt[win] != '0);
    neg     = last[win] < first[win];
    cnt_ext = {{rwps_pkg::COUNT_W{1'b0}}, cnt[win]};
    pip_mag = prod[win][rwps_pkg::PIP_SHIFT +: rwps_pkg::PIP_W];
    mean_o  = nz ? mean[win] : '0;
    vol_o   = nz ? vol[win] : '0;
    pc_o    = nz ? ({1'b0, last[win]} - {1'b0, first[win]}) : '0;
    pip_o   = !nz ? '0 : (neg ? '0 - pip_mag : pip_mag);
  end

  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tuser  = win;
  assign m_axis_tlast  = win;
  assign m_axis_tdata  = {1'b0, pip_o, pc_o, vol_o, mean_o,
                          cnt_ext[rwps_pkg::COUNT_W-1:0], t_cur, start_w[win]};

  // The new tick always lies inside both of its own windows.
  `RWPS_IMPLY(a_window_not_empty, m_axis_tvalid, cnt[win] != '0, "empty window on output")
  `RWPS_ALWAYS(a_no_overlap, !(s_axis_tready && m_axis_tvalid), "input taken during output")
  `RWPS_ALWAYS(a_fill_bound, fill <= CW'(HISTORY_DEPTH), "fill count beyond depth")
  `RWPS_NEXT(a_final_beat_idle, m_axis_tvalid && m_axis_tready && m_axis_tlast,
    s_axis_tready, "not idle after final result beat")

endmodule

// File: sv/rwps_ram.sv
module rwps_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/rwps_div.sv
module rwps_div #(
  parameter int NUM_W = 75,
  parameter int DEN_W = 11
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_W-1:0]    num,
  input  logic [DEN_W-1:0]    den,
  output rwps_pkg::unit_stat_t stat,
  output logic [NUM_W-1:0]    quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] qr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Restoring division, one quotient bit per cycle, dividend shifted out of qr.
  assign trial = {rem, qr[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        qr    <= num;
        den_r <= den;
        rem   <= '0;
        cnt   <= CNT_W'(NUM_W);
      end else if (busy) begin
        rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        qr  <= {qr[NUM_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quo       = qr;

endmodule

// File: sv/rwps_isqrt.sv
module rwps_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rwps_pkg::VAR_W-1:0]  value,
  output rwps_pkg::unit_stat_t        stat,
  output logic [rwps_pkg::ROOT_W-1:0] root
);

  localparam int VW = rwps_pkg::VAR_W;
  localparam int RW = rwps_pkg::ROOT_W;
  localparam int CNT_W = $clog2(RW + 1);

  logic [VW-1:0]    v;
  logic [RW+1:0]    rem;
  logic [RW-1:0]    root_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [RW+1:0]    shifted;
  logic [RW+1:0]    trial;
  logic             ge;

  // Digit-by-digit square root: two radicand bits in, one root bit out per cycle.
  assign shifted = {rem[RW-1:0], v[VW-1:VW-2]};
  assign trial   = {root_r, 2'b01};
  assign ge      = shifted >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy   <= 1'b1;
        v      <= value;
        rem    <= '0;
        root_r <= '0;
        cnt    <= CNT_W'(RW);
      end else if (busy) begin
        v      <= {v[VW-3:0], 2'b00};
        rem    <= ge ? shifted - trial : shifted;
        root_r <= {root_r[RW-2:0], ge};
        cnt    <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign root      = root_r;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rwps_pkg::*;

  localparam int RING_DEPTH = HISTORY_DEPTH_DEF;
  localparam int IDLE_LIMIT = 20000;
  localparam int RX_HOLD_CYCLES = 3000;
  localparam logic [WIN_W-1:0] WIN_MAX = {WIN_W{1'b1}};

  typedef struct {
    logic [PRICE_W-1:0] price;
    logic [TIME_W-1:0]  ts;
  } tick_t;

  typedef struct {
    logic                      kind;
    logic [TIME_W-1:0]         span_start;
    logic [TIME_W-1:0]         span_end;
    logic [COUNT_W-1:0]        count;
    logic [PRICE_W-1:0]        mean;
    logic [ROOT_W-1:0]         vol;
    logic signed [PC_W-1:0]    change;
    logic signed [PIP_W-1:0]   pips;
    logic                      last;
  } window_stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [WIN_W-1:0]      cfg_data = '0;

  rolling_window_price_stats uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow of the block's state: the history ring and the two window lengths.
  logic [PRICE_W-1:0] hist_price [RING_DEPTH];
  logic [TIME_W-1:0]  hist_time  [RING_DEPTH];
  int unsigned        hist_wr;
  int unsigned        hist_fill;
  logic [WIN_W-1:0]   short_len;
  logic [WIN_W-1:0]   long_len;

  tick_t         pending_ticks[$];
  window_stats_t expected_stats[$];
  tick_t         cur_tick;
  int            errors = 0;
  int            ticks_accepted = 0;
  int            tx_gap = 0;
  int            rx_gap = 0;
  bit            no_idle = 1'b0;
  logic          rx_hold = 1'b0;
  int            quiet_cycles = 0;

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Statistics of one window ending at t, scanned oldest first.
  function automatic window_stats_t window_stats(input logic [TIME_W-1:0] t,
                                                 input logic [WIN_W-1:0] len,
                                                 input logic kind);
    window_stats_t r;
    int unsigned   oldest;
    int unsigned   idx;
    logic [127:0]  sum;
    logic [127:0]  sq_sum;
    logic [63:0]   n;
    logic [63:0]   avg;
    logic [63:0]   dev;
    logic [63:0]   first;
    logic [63:0]   latest;
    logic [63:0]   mag;
    logic [127:0]  var_q;
    logic [63:0]   root_v;
    logic [63:0]   wide_v;
    r.kind = kind;
    r.last = kind;
    r.span_end = t;
    r.span_start = (t >= {14'd0, len}) ? t - {14'd0, len} : '0;
    oldest = (hist_wr + RING_DEPTH - hist_fill) % RING_DEPTH;
    sum = 0; sq_sum = 0; n = 0; first = 0; latest = 0; avg = 0;
    for (int k = 0; k < hist_fill; k++) begin
      idx = (oldest + k) % RING_DEPTH;
      if (hist_time[idx] >= r.span_start && hist_time[idx] <= t) begin
        if (n == 0) first = hist_price[idx];
        latest = hist_price[idx];
        sum += hist_price[idx];
        n++;
      end
    end
    r.count = n[COUNT_W-1:0];
    r.mean = '0; r.vol = '0; r.change = '0; r.pips = '0;
    if (n != 0) begin
      avg = 64'(sum / {64'd0, n});
      for (int k = 0; k < hist_fill; k++) begin
        idx = (oldest + k) % RING_DEPTH;
        if (hist_time[idx] >= r.span_start && hist_time[idx] <= t) begin
          dev = (hist_price[idx] >= avg) ? hist_price[idx] - avg : avg - hist_price[idx];
          sq_sum += dev * dev;
        end
      end
      var_q = sq_sum / {64'd0, n};
      r.mean = avg[PRICE_W-1:0];
      root_v = isqrt(var_q[63:0]);
      r.vol = root_v[ROOT_W-1:0];
      if (latest >= first) begin
        mag = latest - first;
        r.change = mag[PC_W-1:0];
        wide_v = mag / 64'd100;
        r.pips = wide_v[PIP_W-1:0];
      end else begin
        mag = first - latest;
        wide_v = 64'd0 - mag;
        r.change = wide_v[PC_W-1:0];
        wide_v = 64'd0 - (mag / 64'd100);
        r.pips = wide_v[PIP_W-1:0];
      end
    end
    return r;
  endfunction

  // Appends an accepted tick to the shadow ring and queues both window results.
  task automatic record_tick(input tick_t tk);
    hist_price[hist_wr] = tk.price;
    hist_time[hist_wr] = tk.ts;
    hist_wr = (hist_wr + 1) % RING_DEPTH;
    if (hist_fill < RING_DEPTH) hist_fill++;
    expected_stats.insert(expected_stats.size(), window_stats(tk.ts, short_len, 1'b0));
    expected_stats.insert(expected_stats.size(), window_stats(tk.ts, long_len, 1'b1));
    ticks_accepted++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Tick driver: a new beat is loaded only when the current one is accepted or absent.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) record_tick(cur_tick);
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_ticks.size() > 0) begin
        cur_tick = pending_ticks.pop_front();
        s_axis_tdata <= {cur_tick.ts, cur_tick.price};
        s_axis_tvalid <= 1'b1;
        tx_gap = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Result monitor with its own random back-pressure.
  always @(posedge clk) begin
    window_stats_t e;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_stats.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none got %0h", $time, m_axis_tdata);
        end else begin
          e = expected_stats.pop_front();
          check_field("window_kind", e.kind, m_axis_tuser);
          check_field("span_start", e.span_start, m_axis_tdata[63:0]);
          check_field("span_end", e.span_end, m_axis_tdata[127:64]);
          check_field("window_count", e.count, m_axis_tdata[138:128]);
          check_field("avg_price", e.mean, m_axis_tdata[170:139]);
          check_field("volatility", e.vol, m_axis_tdata[202:171]);
          check_field("price_delta", {31'd0, e.change}, m_axis_tdata[235:203]);
          check_field("pip_delta", {37'd0, e.pips}, m_axis_tdata[262:236]);
          check_field("last_result", e.last, m_axis_tlast);
        end
      end
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rx_gap = pick_gap();
      end
    end
  end

  // One long receiver stall while ticks keep coming, so the input side backs up.
  initial begin
    wait (ticks_accepted >= 60);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SHORT_WINDOW) short_len = val;
    else if (idx == REG_LONG_WINDOW) long_len = val;
    cfg_valid <= 1'b0;
  endtask

  // Waits until the block has returned every result and gone quiet.
  task automatic drain();
    wait (pending_ticks.size() == 0 && expected_stats.size() == 0 && !s_axis_tvalid);
    repeat (40) @(posedge clk);
  endtask

  task automatic add_tick(input logic [PRICE_W-1:0] p, input logic [TIME_W-1:0] t);
    tick_t tk;
    tk.price = p;
    tk.ts = t;
    pending_ticks.insert(pending_ticks.size(), tk);
  endtask

  // Random ticks: mostly a forward-moving clock with prices around a base,
  // with duplicates, steps backward and fully random beats mixed in.
  task automatic random_ticks(input int n, input logic [63:0] step_max);
    logic [63:0] clock_ns;
    logic [31:0] base;
    logic [63:0] t;
    logic [31:0] p;
    int r;
    clock_ns = {$urandom, $urandom} >> $urandom_range(8, 40);
    base = $urandom;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        t = clock_ns;
      end else if (r < 88) begin
        clock_ns = clock_ns + ({$urandom, $urandom} % (step_max + 1));
        t = clock_ns;
      end else if (r < 95) begin
        t = clock_ns - ({$urandom, $urandom} % (step_max * 4 + 1));
      end else begin
        t = {$urandom, $urandom};
      end
      p = ($urandom_range(0, 9) == 0) ? $urandom : base + $urandom_range(0, 20000) - 10000;
      add_tick(p, t);
    end
  endtask

  initial begin
    hist_wr = 0;
    hist_fill = 0;
    short_len = SHORT_RESET;
    long_len = LONG_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks under the reset window lengths: price and time extremes,
    // repeated timestamps, falling and rising prices, clamping at zero.
    no_idle = 1'b1;
    add_tick(32'd0, 64'd0);
    add_tick(32'hFFFF_FFFF, 64'd0);
    add_tick(32'd0, 64'd1);
    add_tick(32'd1_234_567, 64'd3_600_000_000_000);
    add_tick(32'd1_234_467, 64'd3_600_000_000_001);
    add_tick(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    add_tick(32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    add_tick(32'd99, 64'hFFFF_FFFF_FFFF_FFFE);
    add_tick(32'd1_100_000, 64'd86_400_000_000_000);
    add_tick(32'd1_100_199, 64'd86_400_000_000_000);
    drain();

    // A short window of length one and the longest long window, plus writes to indexes that do not exist.
    cfg_write(REG_SHORT_WINDOW, 50'd1);
    cfg_write(REG_LONG_WINDOW, WIN_MAX);
    cfg_write(REG_LONG_WINDOW + 8'd1, $urandom);
    cfg_write({CFG_IDX_W{1'b1}}, WIN_MAX);
    add_tick(32'd500, 64'd10);
    add_tick(32'd700, 64'd11);
    add_tick(32'd600, 64'd11);
    add_tick(32'hFFFF_FFFF, {14'd0, WIN_MAX});
    add_tick(32'd1, {14'd0, WIN_MAX} + 64'd1);
    add_tick(32'hFFFF_FF00, 64'hFFFF_FFFF_FFFF_FFFF);
    no_idle = 1'b0;
    random_ticks(40, 64'd3);
    drain();

    cfg_write(REG_SHORT_WINDOW, WIN_MAX);
    cfg_write(REG_LONG_WINDOW, 50'd1);
    random_ticks(45, 64'd1 << 44);
    drain();

    cfg_write(REG_SHORT_WINDOW, 50'd1000);
    cfg_write(REG_LONG_WINDOW, 50'd50000);
    random_ticks(60, 64'd300);
    drain();

    cfg_write(REG_SHORT_WINDOW, 50'd37);
    cfg_write(REG_LONG_WINDOW, {2'($urandom_range(0, 3)), $urandom, 16'h0} | 50'd5000);
    no_idle = 1'b1;
    random_ticks(30, 64'd20);
    drain();
    no_idle = 1'b0;

    cfg_write(REG_SHORT_WINDOW, SHORT_RESET);
    cfg_write(REG_LONG_WINDOW, LONG_RESET);
    random_ticks(80, 64'd400_000_000_000);
    drain();

    if (errors == 0 && expected_stats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
